@@ rtl/assert_macros.svh @@
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define KMSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// checked on every edge, reset included
`define KMSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

@@ rtl/kmsd_pkg.sv @@
// types, constants and the key map of the keypad scan and debounce block
`default_nettype none

package kmsd_pkg;

  localparam int NUM_KEYS = 15;
  localparam int CNT_W    = 8;
  localparam int ROWS     = 4;
  localparam int COLS     = 3;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] COUNTER_MAX = 8'hFF;

  // direct key positions in the pressed mask
  localparam int KEY_POWER = 0;
  localparam int KEY_PARAM = 6;
  localparam int KEY_UP    = 10;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_MASK   = 1'b1;

  localparam logic [CNT_W-1:0]    CONFIRM_RESET = 8'd70;
  localparam logic [NUM_KEYS-1:0] IGNORE_RESET  = 15'h0040;

  // key bit for each row (rows one to four) and column (columns one to three)
  localparam logic [NUM_KEYS-1:0] KEY_MAP [ROWS][COLS] = '{
    '{15'h0080, 15'h0020, 15'h1000},
    '{15'h0800, 15'h0010, 15'h0004},
    '{15'h0100, 15'h0008, 15'h4000},
    '{15'h0200, 15'h2000, 15'h0002}
  };

  typedef struct packed {
    logic            power_line_n;
    logic            param_line;
    logic            up_line_n;
    logic [ROWS-1:0] row_lines_n;
    logic [COLS-1:0] col_lines_n;
  } kmsd_in_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] raw_pressed;
    logic [NUM_KEYS-1:0] newly_confirmed;
  } kmsd_out_t;

endpackage

`default_nettype wire

@@ rtl/kmsd_decode.sv @@
// decodes the direct key lines and the matrix reads into a pressed mask
`default_nettype none

module kmsd_decode import kmsd_pkg::*; (
  input  kmsd_in_t            lines,
  output logic [NUM_KEYS-1:0] pressed
);

  logic [ROWS-1:0] rows;
  logic [COLS-1:0] cols;
  logic            one_row;

  assign rows    = ~lines.row_lines_n;
  assign cols    = ~lines.col_lines_n;
  // matrix keys count only with exactly one row driven
  assign one_row = (rows != '0) && ((rows & (rows - {{(ROWS-1){1'b0}}, 1'b1})) == '0);

  always_comb begin
    pressed = '0;
    pressed[KEY_POWER] = ~lines.power_line_n;
    pressed[KEY_PARAM] = lines.param_line;
    pressed[KEY_UP]    = ~lines.up_line_n;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (one_row && rows[r] && cols[c]) begin
          pressed = pressed | KEY_MAP[r][c];
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/keypad_matrix_scan_debounce.sv @@
// keypad matrix scan decoder with per-key hold debounce
//
// Each input beat is one scan tick: three direct key lines plus the row and
// column reads of a 4x3 matrix. Each tick gives exactly one output beat with
// the decoded pressed mask and the mask of keys confirmed on that tick.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A tick is registered on input, decoded and debounced combinationally, and
// its result registered on output. One beat per cycle is sustained while the
// output is not stalled; the fifteen hold counters all update together as a
// tick passes to the output register. A stalled output holds its beat; the
// input register still takes one more tick, then in_stall rises until the
// output drains. Reset clears all hold counters, sets confirm_count to 70 and
// ignore_mask to key 6 only. Configuration is written through cfg_we,
// cfg_index, cfg_data, one register per clock; the user must write it only
// while no tick is in flight, which the block itself does not enforce.
`default_nettype none

module keypad_matrix_scan_debounce import kmsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kmsd_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kmsd_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic                s1_valid;
  kmsd_in_t            s1_data;
  logic                out_load;
  logic                s1_move;
  logic                accept;

  logic [CNT_W-1:0]    confirm_count;
  logic [NUM_KEYS-1:0] ignore_mask;

  logic [CNT_W-1:0]    hold_counters      [NUM_KEYS];
  logic [CNT_W-1:0]    hold_counters_next [NUM_KEYS];
  logic [NUM_KEYS-1:0] raw;
  logic [NUM_KEYS-1:0] confirmed;

  assign out_load = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;
  assign accept   = in_valid && !in_stall;

  kmsd_decode u_decode (
    .lines   (s1_data),
    .pressed (raw)
  );

  always_comb begin
    logic [CNT_W-1:0] inc;
    inc       = '0;
    confirmed = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      inc = hold_counters[i] + {{(CNT_W-1){1'b0}}, 1'b1};
      hold_counters_next[i] = hold_counters[i];
      if (!ignore_mask[i]) begin
        if (raw[i]) begin
          if (hold_counters[i] != COUNTER_MAX) begin
            hold_counters_next[i] = inc;
            confirmed[i] = (inc == confirm_count);
          end
        end else begin
          hold_counters_next[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        hold_counters[i] <= '0;
      end
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
      if (s1_move) begin
        for (int i = 0; i < NUM_KEYS; i++) begin
          hold_counters[i] <= hold_counters_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= in_data;
    end
    if (s1_move) begin
      out_data.raw_pressed     <= raw;
      out_data.newly_confirmed <= confirmed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_count <= CONFIRM_RESET;
      ignore_mask   <= IGNORE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONFIRM_COUNT: confirm_count <= cfg_data[CNT_W-1:0];
        REG_IGNORE_MASK:   ignore_mask   <= cfg_data[NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/kmsd_checker.sv @@
// port-level checks on the keypad scan and debounce block
`default_nettype none

`include "assert_macros.svh"

module kmsd_checker import kmsd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire kmsd_out_t out_data
);

  logic [NUM_KEYS-1:0] stray_confirm;

  assign stray_confirm = out_data.newly_confirmed & ~out_data.raw_pressed;

  // a confirmed key must be pressed in the same beat
  `KMSD_ASSERT(a_confirm_pressed, clk, rst, out_valid |-> (stray_confirm == '0))

  // an empty output register always leaves room on the input side
  `KMSD_ASSERT(a_no_stall_when_empty, clk, rst, !out_valid |-> !in_stall)

  // reset empties the output
  `KMSD_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid)

  // a stalled beat stays put
  `KMSD_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data))

endmodule

bind keypad_matrix_scan_debounce kmsd_checker u_kmsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/keypad_matrix_scan_debounce_test.sv @@
// self-checking testbench of the keypad matrix scan and debounce block
module keypad_matrix_scan_debounce_test;
  import kmsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 500;
  localparam kmsd_in_t KEYS_UP = '{power_line_n: 1'b1, param_line: 1'b0, up_line_n: 1'b1,
                                   row_lines_n: 4'hF, col_lines_n: 3'h7};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  kmsd_in_t             in_data = KEYS_UP;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  kmsd_out_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CONFIRM_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [7:0]  hold_count [NUM_KEYS];
  logic [7:0]  confirm_at = 8'd70;
  logic [14:0] skip_mask = 15'h0040;

  kmsd_out_t expected_reports[$];
  kmsd_out_t want_report;
  int        errors = 0;
  int        gap_pct = 25;
  int        stall_pct = 25;
  int        stall_left = 0;
  int        quiet = 0;

  keypad_matrix_scan_debounce i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [14:0] matrix_key(int r, int c);
    int pos;
    pos = 0;
    case (r)
      0: pos = (c == 0) ? 7 : (c == 1) ? 5 : 12;
      1: pos = (c == 0) ? 11 : (c == 1) ? 4 : 2;
      2: pos = (c == 0) ? 8 : (c == 1) ? 3 : 14;
      default: pos = (c == 0) ? 9 : (c == 1) ? 13 : 1;
    endcase
    return 15'(1) << pos;
  endfunction

  // decode one scan tick and advance the hold counters
  function automatic kmsd_out_t debounce_tick(kmsd_in_t t);
    kmsd_out_t   rep;
    logic [3:0]  rows;
    logic [2:0]  cols;
    logic [14:0] pressed;
    logic [14:0] fresh;
    int          sel;
    rows = ~t.row_lines_n;
    cols = ~t.col_lines_n;
    pressed = '0;
    fresh = '0;
    sel = -1;
    if (!t.power_line_n) pressed[KEY_POWER] = 1'b1;
    if (t.param_line) pressed[KEY_PARAM] = 1'b1;
    if (!t.up_line_n) pressed[KEY_UP] = 1'b1;
    for (int r = 0; r < 4; r++)
      if (rows == (4'b0001 << r)) sel = r;
    // matrix keys only count with exactly one row driven
    if (sel >= 0)
      for (int c = 0; c < 3; c++)
        if (cols[c]) pressed |= matrix_key(sel, c);
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (skip_mask[k]) continue;
      if (pressed[k]) begin
        if (hold_count[k] != COUNTER_MAX) begin
          hold_count[k] = hold_count[k] + 8'd1;
          if (hold_count[k] == confirm_at) fresh[k] = 1'b1;
        end
      end else begin
        hold_count[k] = '0;
      end
    end
    rep.raw_pressed = pressed;
    rep.newly_confirmed = fresh;
    return rep;
  endfunction

  function automatic kmsd_in_t random_press();
    kmsd_in_t t;
    t = kmsd_in_t'(10'($urandom_range(1023, 0)));
    if ($urandom_range(9, 0) < 7) t.row_lines_n = ~(4'b0001 << $urandom_range(3, 0));
    return t;
  endfunction

  task automatic send_tick(kmsd_in_t t);
    int gap;
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      gap = $urandom_range(12, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_reports.push_back(debounce_tick(t));
  endtask

  task automatic hold_keys(kmsd_in_t t, int n);
    repeat (n) send_tick(t);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] cc, logic [14:0] im);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_CONFIRM_COUNT;
    cfg_data <= {7'b0, cc};
    @(posedge clk);
    cfg_index <= REG_IGNORE_MASK;
    cfg_data <= im;
    @(posedge clk);
    cfg_we <= 1'b0;
    confirm_at = cc;
    skip_mask = im;
  endtask

  // field extremes and each decode case, reset settings
  task automatic test_decode();
    kmsd_in_t t;
    send_tick(KEYS_UP);
    send_tick('{1'b0, 1'b1, 1'b0, 4'h0, 3'h0});  // all rows driven: direct keys only
    send_tick('{1'b1, 1'b0, 1'b1, 4'hF, 3'h0});  // no row: columns ignored
    for (int r = 0; r < 4; r++) begin
      t = KEYS_UP;
      t.row_lines_n = ~(4'b0001 << r);
      t.col_lines_n = 3'h0;
      send_tick(t);
    end
    for (int c = 0; c < 3; c++) begin
      t = KEYS_UP;
      t.row_lines_n = 4'b1110;
      t.col_lines_n = ~(3'b001 << c);
      send_tick(t);
    end
    send_tick('{1'b1, 1'b0, 1'b1, 4'b1100, 3'h0});
    send_tick('{1'b0, 1'b0, 1'b1, 4'hF, 3'h7});
    send_tick('{1'b1, 1'b1, 1'b1, 4'hF, 3'h7});
    send_tick('{1'b1, 1'b0, 1'b0, 4'hF, 3'h7});
    send_tick(KEYS_UP);
  endtask

  // hold past the reset confirm count; the param key is ignored after reset
  task automatic test_reset_settings();
    hold_keys('{1'b0, 1'b1, 1'b1, 4'b1101, 3'h0}, 72);
    send_tick(KEYS_UP);
  endtask

  // ignored counters keep their value and resume once un-ignored
  task automatic test_ignore_resume();
    kmsd_in_t power_only;
    power_only = '{1'b0, 1'b0, 1'b1, 4'hF, 3'h7};
    set_config(8'd5, 15'h7FFF);
    hold_keys('{1'b0, 1'b1, 1'b0, 4'b1011, 3'h0}, 6);
    send_tick(KEYS_UP);
    set_config(8'd5, 15'h0000);
    hold_keys(power_only, 3);
    set_config(8'd5, 15'h0001);
    hold_keys(KEYS_UP, 2);
    hold_keys(power_only, 2);
    set_config(8'd5, 15'h0000);
    hold_keys(power_only, 3);
    send_tick(KEYS_UP);
  endtask

  // confirmed once at the counter limit, then silent while saturated
  task automatic test_saturation();
    set_config(8'd255, 15'h0000);
    hold_keys('{1'b0, 1'b0, 1'b1, 4'b0111, 3'h0}, 262);
    send_tick(KEYS_UP);
  endtask

  task automatic test_confirm_zero();
    set_config(8'd0, 15'h0000);
    hold_keys('{1'b0, 1'b1, 1'b0, 4'b1110, 3'h0}, 20);
    send_tick(KEYS_UP);
  endtask

  // mostly held presses with random content, some noise and glitches
  task automatic random_holds(int n_items);
    kmsd_in_t p;
    int       len;
    int       sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(4, 0) == 0) begin
        send_tick(kmsd_in_t'(10'($urandom_range(1023, 0))));
        sent++;
      end else begin
        p = random_press();
        len = $urandom_range(int'(confirm_at) + 3, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19, 0) == 0) send_tick(kmsd_in_t'(10'($urandom_range(1023, 0))));
          else send_tick(p);
        end
        hold_keys(KEYS_UP, $urandom_range(2, 1));
        sent += len;
      end
    end
  endtask

  task automatic test_random_holds();
    for (int ph = 0; ph < 5; ph++) begin
      gap_pct = (ph == 2 || ph == 4) ? 0 : 25;
      stall_pct = gap_pct;
      if (ph == 0) set_config(8'd1, 15'h0000);
      else if ($urandom_range(1, 0) == 0) set_config(8'($urandom_range(12, 2)), 15'h0000);
      else set_config(8'($urandom_range(12, 2)), 15'($urandom_range(32767, 0)));
      random_holds(40);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, out_data);
        errors++;
      end else begin
        want_report = expected_reports.pop_front();
        if (out_data.raw_pressed !== want_report.raw_pressed) begin
          $display("%0t: raw_pressed expected %h, got %h", $time,
                   want_report.raw_pressed, out_data.raw_pressed);
          errors++;
        end
        if (out_data.newly_confirmed !== want_report.newly_confirmed) begin
          $display("%0t: newly_confirmed expected %h, got %h", $time,
                   want_report.newly_confirmed, out_data.newly_confirmed);
          errors++;
        end
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(11, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("keypad_matrix_scan_debounce test failed");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NUM_KEYS; k++) hold_count[k] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_decode();
    test_reset_settings();
    test_ignore_resume();
    test_saturation();
    test_confirm_zero();
    test_random_holds();
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("keypad_matrix_scan_debounce test passed");
    end else begin
      $display("keypad_matrix_scan_debounce test failed");
    end
    $finish;
  end

endmodule

@@ keypad_matrix_scan_debounce.f @@
+incdir+rtl
rtl/kmsd_pkg.sv
rtl/kmsd_decode.sv
rtl/keypad_matrix_scan_debounce.sv
rtl/kmsd_checker.sv
tb/keypad_matrix_scan_debounce_test.sv
